// ===== rtl/core/ssplit_pkg.sv =====
// Shared widths and divider request/response types for the stripe request splitter.
package ssplit_pkg;

  // divider datapath widths
  localparam int DVD_W  = 31;  // dividend and quotient
  localparam int REM_W  = 18;  // remainder and divisor (disks times stripe unit)
  localparam int STEP_W = 5;   // iteration count
  localparam int DQ_W   = 5;   // quotient width when dividing an in-row offset by the unit

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [DVD_W-1:0]  dividend;
    logic [STEP_W-1:0] steps;
    logic [REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/ssplit_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by the sequencer.
module ssplit_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssplit_pkg::div_req_t req,
  output ssplit_pkg::div_rsp_t rsp
);
  import ssplit_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DVD_W-1:0]  qd_r;
  logic [REM_W-1:0]  div_r;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    trial;
  logic              fits;

  // partial remainder with next dividend bit, trial subtract
  assign shifted = {rem_r, qd_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign fits    = !trial[REM_W];

  // start reloads at any time; quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
      rem_r  <= req.rem_init;
      qd_r   <= req.dividend;
      div_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
      qd_r  <= {qd_r[DVD_W-2:0], fits};
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = qd_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/stripe_request_splitter_top.sv =====
// Top level of the stripe request splitter: config, sequencer and segment emitter.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_ready  | start_block, block_count
//  out_    | output    | out_valid/out_ready| status, disk_index, disk_address,
//          |           |                    | segment_length, last
//  cfg_    | input     | cfg_we             | cfg_addr, cfg_wdata
//
// Before its first segment a request passes the check state, the row division by
// disks times stripe unit and the disk-index division, all on the one shared
// divider; then one segment per cycle while the output register is free. Empty
// and rejected requests go from the check state to a single final word. After
// reset and after each config write the volume size is rebuilt (a divide plus one
// multiply) with in_ready low. A stalled out_ready holds the emitter; the next
// request is accepted while the final result still waits in the output register.
module stripe_request_splitter_top #(
  parameter int MAX_DISKS          = 16,
  parameter int MAX_REQUEST_BLOCKS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // config write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [30:0]        cfg_wdata,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_block,
  input  logic [6:0]         in_block_count,
  // segment channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [3:0]         out_disk_index,
  output logic [30:0]        out_disk_address,
  output logic [6:0]         out_segment_length,
  output logic               out_last
);
  import ssplit_pkg::*;

  localparam logic [1:0] CFG_NUM_DISKS   = 2'd0;
  localparam logic [1:0] CFG_STRIPE_UNIT = 2'd1;
  localparam logic [1:0] CFG_DISK_BLOCKS = 2'd2;

  typedef enum logic [2:0] {
    S_VSTART, S_VDIV, S_IDLE, S_CHECK, S_ROW, S_DISK, S_EMIT, S_SINGLE
  } state_t;

  state_t      state_r;
  logic [4:0]  num_disks_r;
  logic [12:0] stripe_unit_r;
  logic [30:0] disk_blocks_r;

  logic [35:0] vol_r;
  logic [31:0] raw_r;
  logic [6:0]  cnt_r;
  logic        single_bad_r;
  logic [30:0] row_q_r;
  logic [4:0]  seg_disk_r;
  logic [12:0] off_r;
  logic [30:0] row_base_r;

  logic        out_valid_r;
  logic        out_status_r;
  logic [3:0]  out_disk_index_r;
  logic [30:0] out_disk_address_r;
  logic [6:0]  out_segment_length_r;
  logic        out_last_r;

  logic [4:0]  n_eff;
  logic [12:0] u_eff;
  logic [17:0] width_w;
  logic [30:0] per_disk_w;
  logic [35:0] vol_mul_w;
  logic [43:0] base_mul_w;
  logic [35:0] end_w;
  logic        bad_w;
  logic [12:0] room_w;
  logic [6:0]  seg_len_w;
  logic [4:0]  disk_inc_w;
  logic        wrap_w;
  logic        out_free_w;
  logic        out_load_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ssplit_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_disks_r   <= 5'd2;
      stripe_unit_r <= 13'd4;
      disk_blocks_r <= 31'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_DISKS:   num_disks_r   <= cfg_wdata[4:0];
        CFG_STRIPE_UNIT: stripe_unit_r <= cfg_wdata[12:0];
        CFG_DISK_BLOCKS: disk_blocks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective geometry: clamp disks, zero unit reads as one
  always_comb begin
    n_eff = (32'(num_disks_r) > MAX_DISKS) ? 5'(MAX_DISKS) : num_disks_r;
    u_eff = (stripe_unit_r == 13'd0) ? 13'd1 : stripe_unit_r;
  end

  assign width_w    = {13'd0, n_eff} * {5'd0, u_eff};
  assign per_disk_w = disk_blocks_r - 31'(div_rsp.rem);
  assign vol_mul_w  = {31'd0, n_eff} * {5'd0, per_disk_w};
  assign base_mul_w = {13'd0, row_q_r} * {31'd0, u_eff};

  // range check
  assign end_w = {4'd0, raw_r} + {29'd0, cnt_r};
  assign bad_w = raw_r[31] || (cnt_r > 7'(MAX_REQUEST_BLOCKS)) || (end_w > vol_r);

  // segment length: rest of the unit, clipped to what is left
  assign room_w     = u_eff - off_r;
  assign seg_len_w  = (room_w > {6'd0, cnt_r}) ? cnt_r : room_w[6:0];
  assign disk_inc_w = seg_disk_r + 5'd1;
  assign wrap_w     = (disk_inc_w == n_eff);
  assign out_free_w = !out_valid_r || out_ready;
  assign out_load_w = out_free_w && !cfg_we && (state_r == S_EMIT || state_r == S_SINGLE);

  assign in_ready = (state_r == S_IDLE) && !cfg_we;

  // divider requests from the sequencer
  always_comb begin
    div_req = '0;
    case (state_r)
      S_VSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = disk_blocks_r;
        div_req.steps    = STEP_W'(DVD_W);
        div_req.divisor  = {5'd0, u_eff};
      end
      S_CHECK: begin
        div_req.start    = !bad_w && (cnt_r != 7'd0);
        div_req.dividend = raw_r[30:0];
        div_req.steps    = STEP_W'(DVD_W);
        div_req.divisor  = width_w;
      end
      S_ROW: begin
        // offset in row is below 31 units, so only the low bits need iterating
        div_req.start    = !div_rsp.busy;
        div_req.rem_init = div_rsp.rem >> DQ_W;
        div_req.dividend = {div_rsp.rem[DQ_W-1:0], {(DVD_W-DQ_W){1'b0}}};
        div_req.steps    = STEP_W'(DQ_W);
        div_req.divisor  = {5'd0, u_eff};
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_VSTART;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load_w) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        state_r <= S_VSTART;
      end else begin
        case (state_r)
          S_VSTART: state_r <= S_VDIV;
          S_VDIV: begin
            if (!div_rsp.busy) begin
              vol_r   <= vol_mul_w;
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              raw_r   <= in_start_block;
              cnt_r   <= in_block_count;
              state_r <= S_CHECK;
            end
          end
          S_CHECK: begin
            if (bad_w || cnt_r == 7'd0) begin
              single_bad_r <= bad_w;
              state_r      <= S_SINGLE;
            end else begin
              state_r <= S_ROW;
            end
          end
          S_ROW: begin
            if (!div_rsp.busy) begin
              row_q_r <= div_rsp.quot;
              state_r <= S_DISK;
            end
          end
          S_DISK: begin
            if (!div_rsp.busy) begin
              seg_disk_r <= div_rsp.quot[DQ_W-1:0];
              off_r      <= div_rsp.rem[12:0];
              row_base_r <= base_mul_w[30:0];
              state_r    <= S_EMIT;
            end
          end
          S_EMIT: begin
            if (out_free_w) begin
              out_valid_r          <= 1'b1;
              out_status_r         <= 1'b0;
              out_disk_index_r     <= seg_disk_r[3:0];
              out_disk_address_r   <= row_base_r + {18'd0, off_r};
              out_segment_length_r <= seg_len_w;
              out_last_r           <= (seg_len_w == cnt_r);
              cnt_r                <= cnt_r - seg_len_w;
              off_r                <= 13'd0;
              if (wrap_w) begin
                seg_disk_r <= 5'd0;
                row_base_r <= row_base_r + {18'd0, u_eff};
              end else begin
                seg_disk_r <= disk_inc_w;
              end
              if (seg_len_w == cnt_r) begin
                state_r <= S_IDLE;
              end
            end
          end
          S_SINGLE: begin
            if (out_free_w) begin
              out_valid_r          <= 1'b1;
              out_status_r         <= single_bad_r;
              out_disk_index_r     <= 4'd0;
              out_disk_address_r   <= 31'd0;
              out_segment_length_r <= 7'd0;
              out_last_r           <= 1'b1;
              state_r              <= S_IDLE;
            end
          end
          default: state_r <= S_VSTART;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_disk_index     = out_disk_index_r;
  assign out_disk_address   = out_disk_address_r;
  assign out_segment_length = out_segment_length_r;
  assign out_last           = out_last_r;

`ifndef ASSERT_OFF
  // emitter never runs with nothing left
  a_emit_has_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> cnt_r != 7'd0)
    else $error("emitter active with zero blocks left");

  // shared divider is idle whenever a request may be taken
  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_rsp.busy)
    else $error("divider busy in idle");

  // rejected word is a single empty final word
  a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_segment_length == 7'd0)
    else $error("rejected word not final or not empty");

  // disk walk stays inside the volume's disk count
  a_disk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> seg_disk_r < n_eff)
    else $error("segment disk index out of range");

  // only the final word may carry zero length or a reject status
  a_mid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_segment_length != 7'd0 && !out_status)
    else $error("non-final word empty or rejected");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for the stripe request splitter: segment ledger, stimulus and checks.
`timescale 1ns / 1ps

module testbench;

  localparam int DISK_LIMIT    = 16;
  localparam int REQ_LIMIT     = 64;
  localparam int RANDOM_ITEMS  = 500;
  localparam int ITEMS_PER_CFG = 50;
  localparam int SETTLE_CYCLES = 60;    // idle time after the last expected word
  localparam int HOLD_CYCLES   = 400;   // long receiver back-pressure stretch
  localparam int STALL_LIMIT   = 4000;  // quiet cycles before giving up

  // register map
  localparam logic [1:0] REG_NUM_DISKS   = 2'd0;
  localparam logic [1:0] REG_STRIPE_UNIT = 2'd1;
  localparam logic [1:0] REG_DISK_BLOCKS = 2'd2;

  typedef struct {
    logic        status;
    logic [3:0]  disk;
    logic [30:0] addr;
    logic [6:0]  len;
    logic        last;
  } seg_t;

  // Tracks the register copy, maps requests onto disk segments and checks them.
  class segment_ledger;
    logic [4:0]  disks_reg;
    logic [12:0] unit_reg;
    logic [30:0] blocks_reg;
    seg_t        pending_segments[$];
    int          mismatches;
    int          requests;
    int          rejects;
    int          segments;

    function new();
      disks_reg  = 5'd2;
      unit_reg   = 13'd4;
      blocks_reg = '0;
      mismatches = 0;
      requests   = 0;
      rejects    = 0;
      segments   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] value);
      case (idx)
        REG_NUM_DISKS:   disks_reg  = value[4:0];
        REG_STRIPE_UNIT: unit_reg   = value[12:0];
        REG_DISK_BLOCKS: blocks_reg = value;
        default: ;
      endcase
    endfunction

    function longint unsigned eff_disks();
      return (disks_reg > DISK_LIMIT) ? DISK_LIMIT : disks_reg;
    endfunction

    function longint unsigned eff_unit();
      return (unit_reg == 0) ? 1 : unit_reg;
    endfunction

    // disk size rounded down to whole stripe units, times the disk count
    function longint unsigned volume();
      longint unsigned u;
      longint unsigned per;
      u   = eff_unit();
      per = blocks_reg;
      per = (per / u) * u;
      return eff_disks() * per;
    endfunction

    function int waiting();
      return pending_segments.size();
    endfunction

    function void note_request(logic [31:0] first, logic [6:0] count);
      longint unsigned u;
      longint unsigned row;
      longint unsigned b;
      longint unsigned left;
      longint unsigned off;
      longint unsigned len;
      longint unsigned tmp;
      seg_t s;
      requests++;
      u    = eff_unit();
      row  = eff_disks() * u;
      b    = first;
      left = count;
      s    = '{1'b0, 4'd0, 31'd0, 7'd0, 1'b1};
      // rejected: negative, oversized or past the end of the volume
      if (first[31] || count > REQ_LIMIT || b + left > volume()) begin
        s.status = 1'b1;
        rejects++;
        pending_segments.push_back(s);
        return;
      end
      // empty request answers with one zero-length word
      if (left == 0) begin
        pending_segments.push_back(s);
        return;
      end
      while (left > 0) begin
        off    = b % u;
        tmp    = (b % row) / u;
        s.disk = tmp[3:0];
        tmp    = (b / row) * u + off;
        s.addr = tmp[30:0];
        len    = u - off;
        if (len > left) len = left;
        left  -= len;
        b     += len;
        s.len  = len[6:0];
        s.last = (left == 0);
        pending_segments.push_back(s);
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t exp;
      segments++;
      if (pending_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word st=%0d disk=%0d addr=%0d len=%0d last=%0d",
                   $time, got.status, got.disk, got.addr, got.len, got.last);
        return;
      end
      exp = pending_segments.pop_front();
      if (got.status !== exp.status || got.disk !== exp.disk || got.addr !== exp.addr ||
          got.len !== exp.len || got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp st=%0d disk=%0d addr=%0d len=%0d last=%0d",
                   $time, exp.status, exp.disk, exp.addr, exp.len, exp.last);
          $display("%0t:          got st=%0d disk=%0d addr=%0d len=%0d last=%0d",
                   $time, got.status, got.disk, got.addr, got.len, got.last);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [30:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_start_block;
  logic [6:0]         in_block_count;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status;
  logic [3:0]         out_disk_index;
  logic [30:0]        out_disk_address;
  logic [6:0]         out_segment_length;
  logic               out_last;

  segment_ledger ledger;
  int send_idle_pct = 17;
  int recv_idle_pct = 54;
  int settings = 0;
  int holds = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  stripe_request_splitter_top #(
    .MAX_DISKS          (DISK_LIMIT),
    .MAX_REQUEST_BLOCKS (REQ_LIMIT)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_block     (in_start_block),
    .in_block_count     (in_block_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_disk_index     (out_disk_index),
    .out_disk_address   (out_disk_address),
    .out_segment_length (out_segment_length),
    .out_last           (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold when asked
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin : monitor
    seg_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        ledger.note_request(in_start_block, in_block_count);
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.disk   = out_disk_index;
        got.addr   = out_disk_address;
        got.len    = out_segment_length;
        got.last   = out_last;
        ledger.check_segment(got);
      end
    end
  end

  // watchdog: too long without any word moving ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles, %0d words still expected",
             quiet, ledger.waiting());
    $display("status: fail");
    $finish;
  end

  task automatic send_request(logic [31:0] first, logic [6:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_start_block <= first;
    in_block_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every expected word, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.set_reg(idx, value);
  endtask

  task automatic apply_config(logic [4:0] nd, logic [12:0] su, logic [30:0] db);
    settle();
    write_reg(REG_NUM_DISKS, {26'd0, nd});
    write_reg(REG_STRIPE_UNIT, {18'd0, su});
    write_reg(REG_DISK_BLOCKS, db);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // mostly sane geometry, now and then zero, oversized or unaligned values
  task automatic random_config();
    logic [4:0]  nd;
    logic [12:0] su;
    logic [30:0] db;
    longint unsigned ue;
    longint unsigned extra;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)       nd = 5'd0;
    else if (pick < 13) nd = 5'($urandom_range(31, DISK_LIMIT + 1));
    else                nd = 5'($urandom_range(DISK_LIMIT, 1));
    pick = $urandom_range(99);
    if (pick < 5)       su = 13'd0;
    else if (pick < 60) su = 13'($urandom_range(8, 1));
    else if (pick < 85) su = 13'($urandom_range(64, 9));
    else if (pick < 95) su = 13'($urandom_range(4096, 65));
    else                su = 13'($urandom_range(8191, 4097));
    ue = (su == 0) ? 1 : su;
    extra = (ue > 1) ? $urandom_range(32'(ue - 1), 1) : 0;
    pick = $urandom_range(99);
    if (pick < 45)      db = 31'(ue * $urandom_range(64, 1));
    else if (pick < 60) db = 31'(ue * $urandom_range(64, 1) + extra);
    else if (pick < 92) db = 31'($urandom() >> 1);
    else if (pick < 96) db = 31'h7FFF_FFFF;
    else                db = 31'd0;
    apply_config(nd, su, db);
  endtask

  // mostly in-range requests, some just past the end, some negative, some noise
  task automatic random_request();
    longint unsigned vol;
    longint unsigned hi;
    logic [31:0] first;
    logic [6:0]  cnt;
    int pick;
    vol  = ledger.volume();
    pick = $urandom_range(99);
    cnt  = 7'($urandom_range(REQ_LIMIT));
    if (pick < 72 && vol >= cnt) begin
      hi = vol - cnt;
      if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
      if (pick < 8)       first = hi[31:0];
      else if (pick < 14) first = 32'd0;
      else                first = $urandom_range(hi[31:0], 0);
    end else if (pick < 82) begin
      hi = (vol + 1 > cnt) ? vol + 1 - cnt : 0;
      if (hi > 64'h7FFF_FFFF) hi = $urandom() & 32'h7FFF_FFFF;
      first = hi[31:0];
    end else if (pick < 91) begin
      first = $urandom() | 32'h8000_0000;
    end else begin
      first = $urandom();
      cnt   = 7'($urandom_range(127));
    end
    send_request(first, cnt);
  endtask

  // main sequence
  initial begin
    ledger         = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_NUM_DISKS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_start_block = '0;
    in_block_count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: zero-size volume, only an empty request at zero passes
    send_request(32'd0, 7'd0);
    send_request(32'd0, 7'd1);
    send_request(32'hFFFF_FFFF, 7'd0);

    // four disks, unit 4, 256-block volume: edges and rejects
    apply_config(5'd4, 13'd4, 31'd64);
    send_request(32'd0, 7'd64);
    send_request(32'd3, 7'd10);
    send_request(32'd255, 7'd1);
    send_request(32'd256, 7'd0);
    send_request(32'd256, 7'd1);
    send_request(32'd192, 7'd64);
    send_request(32'd193, 7'd64);
    send_request(32'h8000_0000, 7'd1);
    send_request(32'h7FFF_FFFF, 7'd0);
    send_request(32'd5, 7'd65);
    send_request(32'd0, 7'd127);

    // too many disks clamps to the limit, zero unit acts as one
    apply_config(5'd20, 13'd0, 31'd10);
    send_request(32'd150, 7'd10);
    send_request(32'd7, 7'd33);

    // no disks at all
    apply_config(5'd0, 13'd4096, 31'h7FFF_FFFF);
    send_request(32'd0, 7'd0);
    send_request(32'd0, 7'd1);

    // widest geometry, unaligned disk size rounds down
    apply_config(5'd16, 13'd4096, 31'h7FFF_FFFF);
    send_request(32'h7FFF_FFBF, 7'd64);
    send_request(32'd4090, 7'd64);

    // single disk, unit 1: one word per block
    apply_config(5'd1, 13'd1, 31'd64);
    send_request(32'd0, 7'd64);
    send_request(32'd63, 7'd1);

    // largest disk count and stripe unit register values
    apply_config(5'd31, 13'd8191, 31'd16383);
    send_request(32'd8180, 7'd64);
    send_request(32'd262100, 7'd12);

    // random part
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % ITEMS_PER_CFG == 0) random_config();
      if (k == RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 17;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (k == RANDOM_ITEMS / 2 || k == 5 * RANDOM_ITEMS / 6) begin
        hold_request = 1'b1;
        holds++;
      end
      random_request();
    end

    settle();
    $display("requests %0d (%0d rejected), words checked %0d, register settings %0d",
             ledger.requests, ledger.rejects, ledger.segments, settings);
    $display("idle mixes 17/54, 54/17 and none; %0d long receiver holds; %0d mismatches",
             holds, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.waiting() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ssplit_pkg.sv
rtl/core/ssplit_div.sv
rtl/core/stripe_request_splitter_top.sv
dv/testbench.sv
